@@ rtl/nde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nde_pkg
// Shared widths, register map, transaction structs and small arithmetic
// helpers for the neighbor difference edge detector.
// ----------------------------------------------------------------------------
package nde_pkg;

   localparam int CHAN_W     = 8;
   localparam int SUM_W      = 10;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 16;
   localparam int THR_W      = 10;
   localparam int FW_W       = 11;
   localparam int FH_W       = 16;
   localparam int LINE_DEPTH = 1 << COL_W;

   localparam int BANKS  = 3;
   localparam int BANK_W = 2;
   localparam int SLOTS  = 3;

   localparam int REQ_DATA_W    = 3 * CHAN_W;
   localparam int RSP_FIELDS_W  = ROW_W + COL_W + 1 + SUM_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(200);
   localparam logic [FW_W-1:0]  WIDTH_RESET     = FW_W'(16);
   localparam logic [FH_W-1:0]  HEIGHT_RESET    = FH_W'(16);

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_WIDTH     = 2'd1,
      REG_HEIGHT    = 2'd2
   } reg_index_type;

   // Per-pixel attributes, resolved at acceptance.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             has_up;
      logic             has_up2;
      logic             has_left;
      logic             has_left2;
      logic             has_right;
      logic             last_row;
      logic             last_col;
      logic             col_clamped;
   } pix_info_type;

   // Line buffer read taps for the pixel in the compute stage.
   typedef struct packed {
      logic [SUM_W-1:0] prev_ctr;
      logic [SUM_W-1:0] prev_right;
      logic [SUM_W-1:0] older_ctr;
      logic [SUM_W-1:0] cur_left;
      logic [SUM_W-1:0] cur_left2;
   } line_taps_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             is_edge;
      logic [SUM_W-1:0] max_diff;
      logic             frame_last;
   } result_type;

   // Up to three decided pixels from one accepted pixel, in raster order.
   typedef struct packed {
      logic [SLOTS-1:0]             valid;
      result_type [SLOTS-1:0]       slot;
   } cand_type;

   function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [SUM_W-1:0] max_of(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

@@ rtl/nde_line_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nde_line_ram
// One row of channel sums: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module nde_line_ram import nde_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [SUM_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr_a,
   input  logic [COL_W-1:0] rd_addr_b,
   output logic [SUM_W-1:0] rd_data_a,
   output logic [SUM_W-1:0] rd_data_b
);

   logic [SUM_W-1:0] mem_ff [LINE_DEPTH];
   logic [SUM_W-1:0] rd_data_a_ff;
   logic [SUM_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ rtl/nde_line_buffers.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nde_line_buffers
// Three row banks with rotating roles: current, previous and older row.
// ----------------------------------------------------------------------------
module nde_line_buffers import nde_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             row_end,
   input  logic             col_clamped,
   input  logic [COL_W-1:0] col,
   input  logic [SUM_W-1:0] sum,
   output line_taps_type    taps
);

   logic [BANK_W-1:0] cur_ff, cur_in;
   logic [BANK_W-1:0] rd_cur_ff, rd_cur_in;
   logic [SUM_W-1:0]  q_a [BANKS];
   logic [SUM_W-1:0]  q_b [BANKS];
   logic [COL_W-1:0]  col_next;
   logic [COL_W-1:0]  col_prev;
   logic [COL_W-1:0]  col_prev2;

   assign col_next  = col + COL_W'(1);
   assign col_prev  = col - COL_W'(1);
   assign col_prev2 = col - COL_W'(2);

   // A clamped pixel sits on the last column, so the right tap is idle: port b
   // fetches the left column and the current bank's port a two columns back.
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      nde_line_ram u_ram (
         .clock     (clock),
         .wr_en     (accept && (cur_ff == BANK_W'(b))),
         .wr_addr   (col),
         .wr_data   (sum),
         .rd_en     (accept),
         .rd_addr_a ((col_clamped && (cur_ff == BANK_W'(b))) ? col_prev2 : col),
         .rd_addr_b (col_clamped ? col_prev : col_next),
         .rd_data_a (q_a[b]),
         .rd_data_b (q_b[b])
      );
   end

   // Rotate at row end: older takes previous, previous takes current.
   always_comb begin
      cur_in    = cur_ff;
      rd_cur_in = rd_cur_ff;
      if (accept) begin
         rd_cur_in = cur_ff;
         if (row_end) begin
            cur_in = (cur_ff == BANK_W'(BANKS - 1)) ? '0 : cur_ff + BANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         rd_cur_ff <= '0;
      end else begin
         cur_ff    <= cur_in;
         rd_cur_ff <= rd_cur_in;
      end
   end

   // Steer read data by the roles in force when it was read.
   always_comb begin
      case (rd_cur_ff)
         2'd0: begin
            taps.prev_ctr   = q_a[2];
            taps.prev_right = q_b[2];
            taps.older_ctr  = q_a[1];
            taps.cur_left   = q_b[0];
            taps.cur_left2  = q_a[0];
         end
         2'd1: begin
            taps.prev_ctr   = q_a[0];
            taps.prev_right = q_b[0];
            taps.older_ctr  = q_a[2];
            taps.cur_left   = q_b[1];
            taps.cur_left2  = q_a[1];
         end
         2'd2: begin
            taps.prev_ctr   = q_a[1];
            taps.prev_right = q_b[1];
            taps.older_ctr  = q_a[0];
            taps.cur_left   = q_b[2];
            taps.cur_left2  = q_a[2];
         end
         default: begin
            taps.prev_ctr   = q_a[0];
            taps.prev_right = q_b[0];
            taps.older_ctr  = q_a[0];
            taps.cur_left   = q_b[0];
            taps.cur_left2  = q_a[0];
         end
      endcase
   end

endmodule

@@ rtl/nde_diff_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nde_diff_core
// Compute stage: holds one pixel with its neighbor sums and forms the
// neighbor differences and edge decisions for every pixel it settles.
// ----------------------------------------------------------------------------
module nde_diff_core import nde_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  pix_info_type     pix,
   input  line_taps_type    taps,
   input  logic [THR_W-1:0] threshold,
   output logic             in_ready,
   output logic             cand_valid,
   output cand_type         cand,
   input  logic             take
);

   logic             valid_ff, valid_in;
   pix_info_type     info_ff;
   logic [SUM_W-1:0] p_left_ff;
   logic [SUM_W-1:0] c1_ff;
   logic [SUM_W-1:0] c2_ff;
   logic [SUM_W-1:0] p_left, c1, c2;
   logic [SUM_W-1:0] m_up, m_left, m_self;

   assign in_ready   = !valid_ff || take;
   assign cand_valid = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Shift the row windows: previous row left tap, and the two last sums.
   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff   <= pix;
         p_left_ff <= taps.prev_ctr;
         c1_ff     <= info_ff.sum;
         c2_ff     <= c1_ff;
      end
   end

   always_comb begin
      // A clamped pixel skipped columns, so take its left sums from the banks.
      if (info_ff.col_clamped) begin
         p_left = taps.prev_right;
         c1     = taps.cur_left;
         c2     = taps.cur_left2;
      end else begin
         p_left = p_left_ff;
         c1     = c1_ff;
         c2     = c2_ff;
      end

      // Pixel above, decided now that its lower neighbor is here.
      m_up = abs_diff(taps.prev_ctr, info_ff.sum);
      if (info_ff.has_left) begin
         m_up = max_of(m_up, abs_diff(taps.prev_ctr, p_left));
      end
      if (info_ff.has_right) begin
         m_up = max_of(m_up, abs_diff(taps.prev_ctr, taps.prev_right));
      end
      if (info_ff.has_up2) begin
         m_up = max_of(m_up, abs_diff(taps.prev_ctr, taps.older_ctr));
      end

      // Left pixel on the last row.
      m_left = abs_diff(c1, info_ff.sum);
      if (info_ff.has_left2) begin
         m_left = max_of(m_left, abs_diff(c1, c2));
      end
      if (info_ff.has_up) begin
         m_left = max_of(m_left, abs_diff(c1, p_left));
      end

      // Final pixel of the frame.
      m_self = '0;
      if (info_ff.has_left) begin
         m_self = max_of(m_self, abs_diff(info_ff.sum, c1));
      end
      if (info_ff.has_up) begin
         m_self = max_of(m_self, abs_diff(info_ff.sum, taps.prev_ctr));
      end

      cand.valid[0] = info_ff.has_up;
      cand.valid[1] = info_ff.last_row && info_ff.has_left;
      cand.valid[2] = info_ff.last_row && info_ff.last_col;

      cand.slot[0].row        = info_ff.row - ROW_W'(1);
      cand.slot[0].col        = info_ff.col;
      cand.slot[0].is_edge    = (m_up > threshold);
      cand.slot[0].max_diff   = m_up;
      cand.slot[0].frame_last = 1'b0;

      cand.slot[1].row        = info_ff.row;
      cand.slot[1].col        = info_ff.col - COL_W'(1);
      cand.slot[1].is_edge    = (m_left > threshold);
      cand.slot[1].max_diff   = m_left;
      cand.slot[1].frame_last = 1'b0;

      cand.slot[2].row        = info_ff.row;
      cand.slot[2].col        = info_ff.col;
      cand.slot[2].is_edge    = (m_self > threshold);
      cand.slot[2].max_diff   = m_self;
      cand.slot[2].frame_last = 1'b1;
   end

endmodule

@@ rtl/nde_result_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nde_result_queue
// Output register for up to three results of one pixel, sent in order.
// ----------------------------------------------------------------------------
module nde_result_queue import nde_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cand_valid,
   input  cand_type              cand,
   output logic                  take,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic [SLOTS-1:0]       mask_ff, mask_in;
   result_type [SLOTS-1:0] slots_ff;
   logic [SLOTS-1:0]       lowest;
   logic [SLOTS-1:0]       rest;
   logic                   pop;
   result_type             head;

   assign lowest     = mask_ff & (~mask_ff + SLOTS'(1));
   assign rest       = mask_ff & ~lowest;
   assign rsp_tvalid = (mask_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign take       = cand_valid && ((mask_ff == '0) || (pop && (rest == '0)));

   always_comb begin
      mask_in = mask_ff;
      if (take) begin
         mask_in = cand.valid;
      end else if (pop) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slots_ff <= cand.slot;
      end
   end

   always_comb begin
      head = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (lowest[i]) begin
            head = slots_ff[i];
         end
      end
   end

   assign rsp_tdata = RSP_DATA_W'({head.max_diff, head.is_edge, head.col, head.row});
   assign rsp_tlast = (rest == '0);
   assign rsp_tuser = head.frame_last;

endmodule

@@ rtl/neighbor_difference_edge_detector_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_difference_edge_detector_top
// Four-neighbor maximum difference edge detector over a raster RGB stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per pixel, and each is reduced
// to the sum of its red, green and blue channels. A pixel is decided once its
// lower neighbor arrives, so the results for row r come out while row r+1
// streams in; on the last row each pixel is decided when its right neighbor
// arrives and the final pixel of the frame at once. Each result carries the
// largest absolute sum difference to the left, right, upper and lower
// neighbors inside the frame and an edge flag when that value is strictly
// above edge_threshold. The block takes one pixel per clock unless the result
// port holds it back: an accepted pixel is registered in the compute stage
// and moves on into the output register once that is empty or sending its
// last result; the pixel's results go out from there. Rows before the
// last give one result per pixel (none for row 0); on the last row a pixel
// past column 0 gives two results and the final pixel three (one fewer each
// on a single-row frame); the single result port sends one per cycle while
// rsp_tready is high, so extra results stall the input. Three 1024-entry
// line banks hold the sums of the current and the two rows above and swap
// roles at each row end; they need no clearing after reset. Write
// edge_threshold, frame_width and frame_height only while the block is idle.
// ----------------------------------------------------------------------------
module neighbor_difference_edge_detector_top import nde_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // pixel transactions
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_red, pixel_green, pixel_blue
   // result transactions
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_row, out_column, is_edge,
                                              // max_difference, zero pad
   output logic                  rsp_tlast,   // run_last
   output logic                  rsp_tuser,   // frame_last
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [THR_W-1:0] threshold_ff;
   logic [FW_W-1:0]  width_ff;
   logic [FH_W-1:0]  height_ff;
   logic             csr_write;
   reg_index_type    csr_index;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic [FW_W-1:0]  width_m1_full;
   logic [COL_W-1:0] width_m1;
   logic [ROW_W-1:0] height_m1;
   logic [COL_W-1:0] col_now;
   logic [ROW_W-1:0] row_now;

   logic             accept;
   logic             core_ready;
   pix_info_type     pix;
   line_taps_type    taps;
   logic             cand_valid;
   cand_type         cand;
   logic             take;

   // ------------------------------------------------------------------------
   // Register port: zero wait states, write on the access phase.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_pwdata[THR_W-1:0];
            REG_WIDTH:     width_ff     <= csr_pwdata[FW_W-1:0];
            REG_HEIGHT:    height_ff    <= csr_pwdata[FH_W-1:0];
            default: begin
               // drop writes to unmapped addresses
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(threshold_ff);
         REG_WIDTH:     csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT:    csr_prdata = CSR_DATA_W'(height_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Frame geometry: clamp width to 1..LINE_DEPTH, height to at least 1, and
   // treat a counter past the frame as the last column or row.
   // ------------------------------------------------------------------------
   assign width_m1_full = width_ff - FW_W'(1);

   always_comb begin
      if (width_ff == '0) begin
         width_m1 = '0;
      end else if (width_ff > FW_W'(LINE_DEPTH)) begin
         width_m1 = COL_W'(LINE_DEPTH - 1);
      end else begin
         width_m1 = width_m1_full[COL_W-1:0];
      end
      height_m1 = (height_ff == '0) ? '0 : height_ff - ROW_W'(1);
      col_now   = (col_ff > width_m1) ? width_m1 : col_ff;
      row_now   = (row_ff > height_m1) ? height_m1 : row_ff;
   end

   // A clamped column no longer follows the previous pixel, so its left sums
   // come from the line banks instead of the compute stage shift registers.
   always_comb begin
      pix.sum         = SUM_W'(req_tdata[CHAN_W-1:0])
                      + SUM_W'(req_tdata[2*CHAN_W-1:CHAN_W])
                      + SUM_W'(req_tdata[3*CHAN_W-1:2*CHAN_W]);
      pix.row         = row_now;
      pix.col         = col_now;
      pix.has_up      = (row_now != '0);
      pix.has_up2     = (row_now > ROW_W'(1));
      pix.has_left    = (col_now != '0);
      pix.has_left2   = (col_now > COL_W'(1));
      pix.has_right   = (col_now != width_m1);
      pix.last_row    = (row_now == height_m1);
      pix.last_col    = (col_now == width_m1);
      pix.col_clamped = (col_ff > width_m1);
   end

   // ------------------------------------------------------------------------
   // Raster position: advance on every accepted pixel, wrap at row and frame.
   // ------------------------------------------------------------------------
   assign req_tready = core_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (pix.last_col) begin
            col_in = '0;
            row_in = pix.last_row ? '0 : row_now + ROW_W'(1);
         end else begin
            col_in = col_now + COL_W'(1);
            row_in = row_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ------------------------------------------------------------------------
   // Datapath: line banks feed the compute stage, which feeds the output
   // register. Read taps and the pixel register load on the same edge.
   // ------------------------------------------------------------------------
   nde_line_buffers u_lines (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .row_end     (pix.last_col),
      .col_clamped (pix.col_clamped),
      .col         (col_now),
      .sum         (pix.sum),
      .taps        (taps)
   );

   nde_diff_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pix        (pix),
      .taps       (taps),
      .threshold  (threshold_ff),
      .in_ready   (core_ready),
      .cand_valid (cand_valid),
      .cand       (cand),
      .take       (take)
   );

   nde_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .cand_valid (cand_valid),
      .cand       (cand),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   // The final pixel of a frame always closes its run.
   a_frame_last_closes_run: assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast
   ) else $error("frame_last result is not the last of its run");

   // Input only stalls behind pending results.
   a_stall_has_cause: assert property (
      @(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid
   ) else $error("input stalled with no result pending");

   // The final pixel of a frame wraps the raster position to the origin.
   a_frame_wrap: assert property (
      @(posedge clock) disable iff (reset)
      accept && pix.last_row && pix.last_col |=> (row_ff == '0) && (col_ff == '0)
   ) else $error("raster position did not wrap at frame end");

endmodule
